// File: rtl/core/ppt_pkg.sv
// Shared types and constants for the point-in-polygon test unit.
// No dependencies; imported by every module of the block.
package ppt_pkg;

    // Default coordinate width
    localparam int COORD_WIDTH_DEF = 16;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUERY_X = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUERY_Y = 1'b1;

    // Result codes
    localparam int LOC_WIDTH = 2;
    localparam logic [LOC_WIDTH-1:0] LOC_INSIDE   = 2'd0;
    localparam logic [LOC_WIDTH-1:0] LOC_BOUNDARY = 2'd1;
    localparam logic [LOC_WIDTH-1:0] LOC_OUTSIDE  = 2'd2;

    // Result word width, padded to whole bytes
    localparam int OUT_TDATA_WIDTH = 8;

    // Which edges a stage carries and whether it closes the polygon
    typedef struct packed {
        logic last;         // closing vertex: emit a result
        logic edge_a_valid; // previous vertex -> this vertex
        logic edge_b_valid; // this vertex -> first vertex
    } stage_ctrl_t;

    // Per-edge outcome
    typedef struct packed {
        logic boundary; // query lies on this edge
        logic toggle;   // ray crosses this edge to the right
    } edge_flags_t;

endpackage

// File: rtl/core/ppt_edge_former.sv
// Input stage: tracks first and previous vertex; forms new and closing edges.
// Depends on ppt_pkg.
module ppt_edge_former #(
    parameter int COORD_WIDTH = ppt_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // incoming vertex word
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic                          last_vertex,
    // stage 1 output
    output logic                          s1_valid,
    input  logic                          s1_ready,
    output ppt_pkg::stage_ctrl_t          s1_ctrl,
    output logic signed [COORD_WIDTH-1:0] prev_x,
    output logic signed [COORD_WIDTH-1:0] prev_y,
    output logic signed [COORD_WIDTH-1:0] cur_x,
    output logic signed [COORD_WIDTH-1:0] cur_y,
    output logic signed [COORD_WIDTH-1:0] close_x,
    output logic signed [COORD_WIDTH-1:0] close_y
);
    import ppt_pkg::*;

    logic                          s1_valid_reg;
    stage_ctrl_t                   s1_ctrl_reg;
    logic signed [COORD_WIDTH-1:0] s1_prev_x_reg, s1_prev_y_reg;
    logic signed [COORD_WIDTH-1:0] s1_cur_x_reg, s1_cur_y_reg;
    logic signed [COORD_WIDTH-1:0] s1_close_x_reg, s1_close_y_reg;

    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic                          mid_reg;
    logic                          accept;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    // Polygon tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            mid_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (!mid_reg)
            begin
                first_x_reg <= vertex_x;
                first_y_reg <= vertex_y;
            end
            prev_x_reg <= vertex_x;
            prev_y_reg <= vertex_y;
            mid_reg    <= !last_vertex;
        end
    end

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_ready)
            s1_valid_reg <= 1'b0;
    end

    // Stage 1 payload; a lone first-and-last vertex closes onto itself
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg.last         <= last_vertex;
            s1_ctrl_reg.edge_a_valid <= mid_reg;
            s1_ctrl_reg.edge_b_valid <= last_vertex;
            s1_prev_x_reg  <= prev_x_reg;
            s1_prev_y_reg  <= prev_y_reg;
            s1_cur_x_reg   <= vertex_x;
            s1_cur_y_reg   <= vertex_y;
            s1_close_x_reg <= mid_reg ? first_x_reg : vertex_x;
            s1_close_y_reg <= mid_reg ? first_y_reg : vertex_y;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctrl  = s1_ctrl_reg;
    assign prev_x   = s1_prev_x_reg;
    assign prev_y   = s1_prev_y_reg;
    assign cur_x    = s1_cur_x_reg;
    assign cur_y    = s1_cur_y_reg;
    assign close_x  = s1_close_x_reg;
    assign close_y  = s1_close_y_reg;

endmodule

// File: rtl/core/ppt_edge_product.sv
// One edge: registered cross and dot products, then boundary and crossing flags.
// Depends on ppt_pkg.
module ppt_edge_product #(
    parameter int COORD_WIDTH = ppt_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    output ppt_pkg::edge_flags_t          flags
);
    import ppt_pkg::*;

    localparam int DW = COORD_WIDTH + 1;   // difference width
    localparam int PW = 2 * DW;            // product width
    localparam int SW = PW + 1;            // sum width

    logic signed [DW-1:0] ex, ey, pxa, pya, pxb, pyb;
    logic signed [PW-1:0] lhs_next, rhs_next, dx_next, dy_next;
    logic signed [PW-1:0] lhs_reg, rhs_reg, dx_reg, dy_reg;
    logic                 straddle_next, straddle_reg;
    logic                 ey_pos_next, ey_pos_reg;
    logic signed [SW-1:0] crs, dot;
    logic                 on_edge, right;

    // Edge and query offsets, one bit wider than the coordinates
    always_comb
    begin
        ex  = {b_x[COORD_WIDTH-1], b_x} - {a_x[COORD_WIDTH-1], a_x};
        ey  = {b_y[COORD_WIDTH-1], b_y} - {a_y[COORD_WIDTH-1], a_y};
        pxa = {query_x[COORD_WIDTH-1], query_x} - {a_x[COORD_WIDTH-1], a_x};
        pya = {query_y[COORD_WIDTH-1], query_y} - {a_y[COORD_WIDTH-1], a_y};
        pxb = {query_x[COORD_WIDTH-1], query_x} - {b_x[COORD_WIDTH-1], b_x};
        pyb = {query_y[COORD_WIDTH-1], query_y} - {b_y[COORD_WIDTH-1], b_y};
        lhs_next = PW'(ex) * PW'(pya);
        rhs_next = PW'(ey) * PW'(pxa);
        dx_next  = PW'(pxa) * PW'(pxb);
        dy_next  = PW'(pya) * PW'(pyb);
        straddle_next = (a_y > query_y) != (b_y > query_y);
        ey_pos_next   = !ey[DW-1] && (ey != '0);
    end

    // Product register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lhs_reg      <= lhs_next;
            rhs_reg      <= rhs_next;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            straddle_reg <= straddle_next;
            ey_pos_reg   <= ey_pos_next;
        end
    end

    // Classify: on the boundary, or crossing to the right of the query
    always_comb
    begin
        crs = {lhs_reg[PW-1], lhs_reg} - {rhs_reg[PW-1], rhs_reg};
        dot = {dx_reg[PW-1], dx_reg} + {dy_reg[PW-1], dy_reg};
        on_edge = (crs == '0) && (dot[SW-1] || dot == '0);
        right   = ey_pos_reg ? (!crs[SW-1] && crs != '0) : crs[SW-1];
        flags.boundary = on_edge;
        flags.toggle   = !on_edge && straddle_reg && right;
    end

endmodule

// File: rtl/core/ppt_accum.sv
// Stage 2 control, parity and boundary accumulation, and the result register.
// Depends on ppt_pkg.
module ppt_accum (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // from the input stage
    input  logic                                   s1_valid,
    output logic                                   s1_ready,
    input  ppt_pkg::stage_ctrl_t                   s1_ctrl,
    // product stage load and its edge outcomes
    output logic                                   s2_load,
    input  ppt_pkg::edge_flags_t                   flags_a,
    input  ppt_pkg::edge_flags_t                   flags_b,
    // result
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [ppt_pkg::LOC_WIDTH-1:0]          location
);
    import ppt_pkg::*;

    logic             s2_valid_reg;
    stage_ctrl_t      s2_ctrl_reg;
    logic             s2_take;
    logic             parity_reg, boundary_reg;
    logic             parity_next, boundary_next;
    logic             out_valid_reg;
    logic [LOC_WIDTH-1:0] location_reg;

    // A non-closing word never waits on the result register
    assign s2_take  = s2_valid_reg && (!s2_ctrl_reg.last || !out_valid_reg || out_ready);
    assign s1_ready = !s2_valid_reg || s2_take;
    assign s2_load  = s1_valid && s1_ready;

    // Stage 2 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_ctrl_reg  <= '0;
        end
        else if (s1_ready)
        begin
            s2_valid_reg <= s1_valid;
            s2_ctrl_reg  <= s1_ctrl;
        end
    end

    // Fold in both edges of this word
    always_comb
    begin
        boundary_next = boundary_reg
                        || (s2_ctrl_reg.edge_a_valid && flags_a.boundary)
                        || (s2_ctrl_reg.edge_b_valid && flags_b.boundary);
        parity_next   = parity_reg
                        ^ (s2_ctrl_reg.edge_a_valid && flags_a.toggle)
                        ^ (s2_ctrl_reg.edge_b_valid && flags_b.toggle);
    end

    // Accumulators, cleared once a polygon closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg   <= 1'b0;
            boundary_reg <= 1'b0;
        end
        else if (s2_take)
        begin
            parity_reg   <= s2_ctrl_reg.last ? 1'b0 : parity_next;
            boundary_reg <= s2_ctrl_reg.last ? 1'b0 : boundary_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_take && s2_ctrl_reg.last)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && s2_ctrl_reg.last)
        begin
            if (boundary_next)
                location_reg <= LOC_BOUNDARY;
            else if (parity_next)
                location_reg <= LOC_INSIDE;
            else
                location_reg <= LOC_OUTSIDE;
        end
    end

    assign out_valid = out_valid_reg;
    assign location  = location_reg;

endmodule

// File: rtl/core/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit.
// Depends on ppt_pkg, ppt_edge_former, ppt_edge_product and ppt_accum.
//
// Usage:
//   Load the query point through the write port (cfg_index 0 = x, 1 = y)
//   while the unit is idle. Stream polygon vertices on the s_ channel, one
//   per word, and mark the final vertex with s_tlast. Each vertex closes an
//   edge with the one before it; the final vertex also closes the edge back
//   to the first. A single-vertex polygon is a degenerate edge.
//   One result word leaves on the m_ channel per polygon: 0 inside,
//   1 on boundary, 2 outside.
// Timing:
//   One vertex per cycle while s_tready is high. After the final vertex is
//   accepted, the result passes the input, product (cross and dot products of
//   both edges, (COORD_WIDTH+1)-bit operands) and result registers.
// Reset clears the query point, the polygon tracking and all valid flags.
// When m_tready is low a finished result waits in the output register;
// vertices that do not close a polygon keep flowing, and s_tready drops
// only once a second closing vertex reaches the accumulator.
module point_in_polygon_test_unit #(
    parameter int COORD_WIDTH = ppt_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // vertex stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // vertex_x, vertex_y (from bit 0 up), zero padded to bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    input  logic                                 s_tlast,   // last_vertex
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // location (bits 1:0), zero padded
    output logic [ppt_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [ppt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_data
);
    import ppt_pkg::*;

    logic signed [COORD_WIDTH-1:0] query_x_reg, query_y_reg;
    logic signed [COORD_WIDTH-1:0] vertex_x, vertex_y;
    logic                          s1_valid, s1_ready, s2_load;
    stage_ctrl_t                   s1_ctrl;
    logic signed [COORD_WIDTH-1:0] prev_x, prev_y, cur_x, cur_y, close_x, close_y;
    edge_flags_t                   flags_a, flags_b;
    logic [LOC_WIDTH-1:0]          location;

    // Query point registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUERY_X: query_x_reg <= cfg_data;
                REG_QUERY_Y: query_y_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Unpack the vertex word
    assign vertex_x = s_tdata[COORD_WIDTH-1:0];
    assign vertex_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    ppt_edge_former #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_former (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (s_tlast),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1_ctrl     (s1_ctrl),
        .prev_x      (prev_x),
        .prev_y      (prev_y),
        .cur_x       (cur_x),
        .cur_y       (cur_y),
        .close_x     (close_x),
        .close_y     (close_y)
    );

    // Edge from the previous vertex to this one
    ppt_edge_product #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge_a (
        .clk     (clk),
        .load    (s2_load),
        .a_x     (prev_x),
        .a_y     (prev_y),
        .b_x     (cur_x),
        .b_y     (cur_y),
        .query_x (query_x_reg),
        .query_y (query_y_reg),
        .flags   (flags_a)
    );

    // Closing edge from this vertex back to the first
    ppt_edge_product #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge_b (
        .clk     (clk),
        .load    (s2_load),
        .a_x     (cur_x),
        .a_y     (cur_y),
        .b_x     (close_x),
        .b_y     (close_y),
        .query_x (query_x_reg),
        .query_y (query_y_reg),
        .flags   (flags_b)
    );

    ppt_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_ctrl   (s1_ctrl),
        .s2_load   (s2_load),
        .flags_a   (flags_a),
        .flags_b   (flags_b),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .location  (location)
    );

    // Pack the result word
    assign m_tdata = {{(OUT_TDATA_WIDTH-LOC_WIDTH){1'b0}}, location};

endmodule
